[sv/modexp_pkg.sv]
// shared types and constants for the modular exponentiation block
package modexp_pkg;

    localparam int BASE_WIDTH = 64;
    localparam int CNT_WIDTH  = 7;
    localparam logic [31:0] MODULUS_RESET = 32'd10000831;
    localparam logic [1:0]  REG_MODULUS   = 2'd0;

    typedef struct packed {
        logic load;
        logic red_step;
        logic mul;
        logic mul_sq;
        logic wr_acc;
        logic wr_sq;
        logic exp_shift;
    } modexp_cmd_t;

    typedef struct packed {
        logic exp_lsb;
    } modexp_status_t;

endpackage

[sv/modexp_dp.sv]
// datapath: multiplier, bit-serial reducer, square, accumulator and exponent registers
module modexp_dp
    import modexp_pkg::*;
#(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 32
)
(
    input  logic                  clk,
    input  modexp_cmd_t           cmd,
    output modexp_status_t        status,
    input  logic [MOD_WIDTH-1:0]  modulus,
    input  logic [63:0]           base,
    input  logic [EXP_WIDTH-1:0]  exponent,
    output logic [MOD_WIDTH-1:0]  result
);

    localparam int PROD_WIDTH = 2 * MOD_WIDTH;

    logic [MOD_WIDTH-1:0]  sq_reg;
    logic [MOD_WIDTH-1:0]  acc_reg;
    logic [MOD_WIDTH-1:0]  rem_reg;
    logic [BASE_WIDTH-1:0] x_reg;
    logic [EXP_WIDTH-1:0]  exp_reg;

    logic [MOD_WIDTH-1:0]  mul_a;
    logic [PROD_WIDTH-1:0] prod;
    logic [MOD_WIDTH:0]    cand;
    logic [MOD_WIDTH:0]    cand_sub;
    logic [MOD_WIDTH-1:0]  rem_next;

    assign mul_a = cmd.mul_sq ? sq_reg : acc_reg;
    assign prod  = PROD_WIDTH'(mul_a) * PROD_WIDTH'(sq_reg);

    // shift in the next dividend bit, subtract once if it reaches the modulus
    assign cand     = {rem_reg, x_reg[BASE_WIDTH-1]};
    assign cand_sub = cand - {1'b0, modulus};
    assign rem_next = (cand >= {1'b0, modulus}) ? cand_sub[MOD_WIDTH-1:0]
                                                : cand[MOD_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= base;
            rem_reg <= '0;
            exp_reg <= exponent;
            acc_reg <= (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
        end
        else
        begin
            if (cmd.mul)
            begin
                x_reg   <= BASE_WIDTH'(prod) << (BASE_WIDTH - PROD_WIDTH);
                rem_reg <= '0;
            end
            else if (cmd.red_step)
            begin
                x_reg   <= {x_reg[BASE_WIDTH-2:0], 1'b0};
                rem_reg <= rem_next;
            end
            if (cmd.wr_acc)
            begin
                acc_reg <= rem_next;
            end
            if (cmd.wr_sq)
            begin
                sq_reg <= rem_next;
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end
    end

    assign status.exp_lsb = exp_reg[0];
    assign result = (modulus == '0) ? '0 : acc_reg;

endmodule

[sv/modexp_ctrl.sv]
// controller state machine sequencing the square-and-multiply steps
module modexp_ctrl
    import modexp_pkg::*;
#(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output modexp_cmd_t    cmd,
    input  modexp_status_t status
);

    localparam int PROD_STEPS = 2 * MOD_WIDTH;
    localparam int BIT_CNT_W  = $clog2(EXP_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_BASE,
        S_NEXT,
        S_MUL_ACC,
        S_RED_ACC,
        S_MUL_SQ,
        S_RED_SQ,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_WIDTH-1:0]   red_cnt_reg, red_cnt_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;

    logic base_last;
    logic prod_last;

    assign base_last = (red_cnt_reg == CNT_WIDTH'(BASE_WIDTH - 1));
    assign prod_last = (red_cnt_reg == CNT_WIDTH'(PROD_STEPS - 1));

    always_comb
    begin
        state_next   = state_reg;
        red_cnt_next = red_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    red_cnt_next = '0;
                    bit_cnt_next = '0;
                    state_next   = S_RED_BASE;
                end
            end
            S_RED_BASE:
            begin
                cmd.red_step = 1'b1;
                red_cnt_next = red_cnt_reg + CNT_WIDTH'(1);
                if (base_last)
                begin
                    cmd.wr_sq  = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                red_cnt_next = '0;
                if (bit_cnt_reg == BIT_CNT_W'(EXP_WIDTH))
                begin
                    state_next = S_DONE;
                end
                else if (status.exp_lsb)
                begin
                    state_next = S_MUL_ACC;
                end
                else
                begin
                    state_next = S_MUL_SQ;
                end
            end
            S_MUL_ACC:
            begin
                cmd.mul      = 1'b1;
                red_cnt_next = '0;
                state_next   = S_RED_ACC;
            end
            S_RED_ACC:
            begin
                cmd.red_step = 1'b1;
                red_cnt_next = red_cnt_reg + CNT_WIDTH'(1);
                if (prod_last)
                begin
                    cmd.wr_acc = 1'b1;
                    state_next = S_MUL_SQ;
                end
            end
            S_MUL_SQ:
            begin
                cmd.mul      = 1'b1;
                cmd.mul_sq   = 1'b1;
                red_cnt_next = '0;
                state_next   = S_RED_SQ;
            end
            S_RED_SQ:
            begin
                cmd.red_step = 1'b1;
                red_cnt_next = red_cnt_reg + CNT_WIDTH'(1);
                if (prod_last)
                begin
                    cmd.wr_sq     = 1'b1;
                    cmd.exp_shift = 1'b1;
                    bit_cnt_next  = bit_cnt_reg + BIT_CNT_W'(1);
                    state_next    = S_NEXT;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            red_cnt_reg <= '0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            red_cnt_reg <= red_cnt_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

[sv/modular_exponentiation.sv]
// top level: modulus register on the apb port, controller and datapath
// each request runs a base reduction, then per exponent bit an optional multiply and a square,
//   each result reduced by the bit-serial reducer, which takes one dividend bit per cycle
// one request at a time, next start taken once the controller has gone from done back to idle
// result holds on power for the single cycle that done is high; receiver cannot stall
// rst_n asynchronous active low: controller idles, modulus returns to 10000831
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [63:0] base,
    input  logic [31:0] exponent,
    // result channel
    output logic        done,
    output logic [31:0] power,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [MOD_WIDTH-1:0] result;
    logic                 cfg_wr;
    modexp_cmd_t          cmd;
    modexp_status_t       status;

    // register writes complete on the access phase; only the modulus decodes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MODULUS);
    assign prdata = (paddr == REG_MODULUS) ? 32'(modulus_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_WIDTH'(MODULUS_RESET);
        end
        else if (cfg_wr)
        begin
            modulus_reg <= pwdata[MOD_WIDTH-1:0];
        end
    end

    // sequencer: base reduction, then per exponent bit an optional multiply and a square
    modexp_ctrl #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // arithmetic: one multiplier for the multiply and square steps, and a restoring reducer shared by all steps
    modexp_dp #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .status   (status),
        .modulus  (modulus_reg),
        .base     (base),
        .exponent (exponent[EXP_WIDTH-1:0]),
        .result   (result)
    );

    assign power = 32'(result);

`ifndef SYNTHESIS
    // a result only appears while a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    // an accepted request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // exactly one result per request: the strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // the result is fully reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (modulus_reg != '0)) |-> (result < modulus_reg))
        else $error("result not below modulus");
`endif

endmodule
